>>> src/sosr_pkg.sv
// Package for the second-order step reference block.
// Holds field widths, register indexes, reset values and the sequencer control types.
// No dependencies.
`default_nettype none

package sosr_pkg;

   localparam int DATA_W      = 32;
   localparam int DT_W        = 24;
   localparam int COEF_W      = 16;
   localparam int PROD_W      = 64;
   localparam int CSR_INDEX_W = 2;

   localparam logic [DATA_W-1:0] STEP_TIME_RESET  = 32'h0100_0000;
   localparam logic [DATA_W-1:0] STEP_VALUE_RESET = 32'h0000_0000;
   localparam logic [COEF_W-1:0] DAMPING_RESET    = 16'd4096;
   localparam logic [COEF_W-1:0] NAT_FREQ_RESET   = 16'd2560;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_STEP_TIME  = 2'd0,
      CSR_STEP_VALUE = 2'd1,
      CSR_DAMPING    = 2'd2,
      CSR_NAT_FREQ   = 2'd3
   } csr_index_type;

   // multiplier passes, in issue order
   typedef enum logic [2:0] {
      OP_W2     = 3'd0,
      OP_TZW    = 3'd1,
      OP_SPRING = 3'd2,
      OP_DAMP   = 3'd3,
      OP_DPOS   = 3'd4,
      OP_AHI    = 3'd5,
      OP_ALO    = 3'd6
   } op_type;

   typedef struct packed {
      logic   idle;
      logic   prep;
      logic   issue;
      logic   capture;
      logic   finish;
      op_type op;
   } ctrl_type;

endpackage

`default_nettype wire

>>> src/sosr_mul.sv
// Shared 32x32 unsigned multiplier with registered product.
// Depends on sosr_pkg.
`default_nettype none

module sosr_mul (
   input  wire                             clock,
   input  wire                             load,
   input  wire  [sosr_pkg::DATA_W-1:0]     operand_a,
   input  wire  [sosr_pkg::DATA_W-1:0]     operand_b,
   output logic [sosr_pkg::PROD_W-1:0]     product
);
   import sosr_pkg::*;

   logic [PROD_W-1:0] product_ff;
   logic [PROD_W-1:0] product_in;

   always_comb begin
      product_in = product_ff;
      if (load) begin
         product_in = PROD_W'(operand_a) * PROD_W'(operand_b);
      end
   end

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

`default_nettype wire

>>> src/sosr_seq.sv
// Sequencer: walks one request through prepare, seven issue/capture multiplier
// passes and the final update. Depends on sosr_pkg.
`default_nettype none

module sosr_seq (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   input  wire                  out_free,
   output sosr_pkg::ctrl_type   ctrl
);
   import sosr_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_PREP    = 5'b00010,
      ST_ISSUE   = 5'b00100,
      ST_CAPTURE = 5'b01000,
      ST_DONE    = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            state_in = ST_ISSUE;
            op_in    = OP_W2;
         end
         ST_ISSUE: begin
            state_in = ST_CAPTURE;
         end
         ST_CAPTURE: begin
            if (op_ff == OP_ALO) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_ISSUE;
               op_in    = op_type'(op_ff + 3'd1);
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_W2;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   always_comb begin
      ctrl.idle    = (state_ff == ST_IDLE);
      ctrl.prep    = (state_ff == ST_PREP);
      ctrl.issue   = (state_ff == ST_ISSUE);
      ctrl.capture = (state_ff == ST_CAPTURE);
      ctrl.finish  = (state_ff == ST_DONE) && out_free;
      ctrl.op      = op_ff;
   end

   a_issue_then_capture: assert property (@(posedge clock) disable iff (reset)
      ctrl.issue |=> ctrl.capture && $stable(op_ff))
      else $error("capture must follow issue of the same pass");

   a_last_pass_done: assert property (@(posedge clock) disable iff (reset)
      ctrl.capture && op_ff == OP_ALO |=> state_ff == ST_DONE)
      else $error("last pass must lead to the update");

   a_start_prep: assert property (@(posedge clock) disable iff (reset)
      ctrl.idle && start |=> ctrl.prep)
      else $error("accepted request must start preparation");

endmodule

`default_nettype wire

>>> src/second_order_step_reference_top.sv
// Top level of the second-order step reference generator: configuration registers,
// filter state and datapath. Depends on sosr_pkg, sosr_mul and sosr_seq.
//
// One request (a tick carrying dt) yields one response holding the new filter
// position in Q16.16. From acceptance until its response sits in the output
// register, a request goes through a preparation step, seven passes through the
// single shared 32x32 multiplier (each an issue step, then a capture step) and
// an update step. One request is in flight at a time; req_stall is high from
// acceptance until the update, and the response register lets the next request
// in while the previous response still waits to be taken. The user is to write
// configuration through csr_* only while no request is in flight (unenforced).
`default_nettype none

module second_order_step_reference_top (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire  [sosr_pkg::DT_W-1:0]             req_tick_dt,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic signed [sosr_pkg::DATA_W-1:0]    rsp_reference_out,
   input  wire                                   csr_write_enable,
   input  wire  [sosr_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire  [sosr_pkg::DATA_W-1:0]           csr_wdata
);
   import sosr_pkg::*;

   ctrl_type ctrl;
   logic     req_accept;
   logic     out_free;

   logic [PROD_W-1:0] product;
   logic [DATA_W-1:0] mul_a;
   logic [DATA_W-1:0] mul_b;

   // configuration
   logic [DATA_W-1:0] step_time_ff, step_time_in;
   logic [DATA_W-1:0] step_value_ff, step_value_in;
   logic [COEF_W-1:0] damping_ff, damping_in;
   logic [COEF_W-1:0] nat_freq_ff, nat_freq_in;

   // filter state
   logic [DATA_W-1:0]        elapsed_ff, elapsed_in;
   logic                     latched_ff, latched_in;
   logic signed [DATA_W-1:0] position_ff, position_in;
   logic signed [DATA_W-1:0] rate_ff, rate_in;

   // working registers
   logic [DT_W-1:0]          dt_ff, dt_in;
   logic [DATA_W-1:0]        rate_mag_ff, rate_mag_in;
   logic [DATA_W-1:0]        w2_ff, w2_in;
   logic [DATA_W-1:0]        tzw_ff, tzw_in;
   logic                     diff_neg_ff, diff_neg_in;
   logic [DATA_W-1:0]        diff_mag_ff, diff_mag_in;
   logic signed [48:0]       spring_ff, spring_in;
   logic signed [49:0]       accel_ff, accel_in;
   logic [48:0]              acc_mag_ff, acc_mag_in;
   logic [DATA_W-1:0]        dpos_ff, dpos_in;
   logic [49:0]              rterm_ff, rterm_in;

   // response
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // combinational helpers
   logic [DATA_W:0]          elapsed_sum;
   logic [DATA_W-1:0]        elapsed_sat;
   logic signed [DATA_W:0]   target;
   logic signed [DATA_W:0]   diff;
   logic signed [DATA_W:0]   diff_abs;
   logic [47:0]              spring_mag;
   logic signed [48:0]       spring_val;
   logic [44:0]              damp_mag;
   logic signed [45:0]       damp_val;
   logic signed [49:0]       accel_abs;
   logic signed [33:0]       dpos_term;
   logic signed [33:0]       pos_sum;
   logic signed [50:0]       rate_term;
   logic signed [50:0]       rate_sum;

   assign req_accept = req_valid && ctrl.idle;
   assign req_stall  = !ctrl.idle;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   sosr_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (req_accept),
      .out_free (out_free),
      .ctrl     (ctrl)
   );

   sosr_mul u_mul (
      .clock     (clock),
      .load      (ctrl.issue),
      .operand_a (mul_a),
      .operand_b (mul_b),
      .product   (product)
   );

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (ctrl.op)
         OP_W2: begin
            mul_a = DATA_W'(nat_freq_ff);
            mul_b = DATA_W'(nat_freq_ff);
         end
         OP_TZW: begin
            mul_a = DATA_W'(damping_ff);
            mul_b = DATA_W'(nat_freq_ff);
         end
         OP_SPRING: begin
            mul_a = diff_mag_ff;
            mul_b = w2_ff;
         end
         OP_DAMP: begin
            mul_a = rate_mag_ff;
            mul_b = tzw_ff;
         end
         OP_DPOS: begin
            mul_a = rate_mag_ff;
            mul_b = DATA_W'(dt_ff);
         end
         OP_AHI: begin
            mul_a = DATA_W'(acc_mag_ff[48:24]);
            mul_b = DATA_W'(dt_ff);
         end
         OP_ALO: begin
            mul_a = DATA_W'(acc_mag_ff[23:0]);
            mul_b = DATA_W'(dt_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      elapsed_sum = {1'b0, elapsed_ff} + (DATA_W+1)'(dt_ff);
      elapsed_sat = elapsed_sum[DATA_W] ? '1 : elapsed_sum[DATA_W-1:0];
      target      = latched_ff ? $signed({step_value_ff[DATA_W-1], step_value_ff})
                               : '0;
      diff        = target - $signed({position_ff[DATA_W-1], position_ff});
      diff_abs    = diff[DATA_W] ? -diff : diff;
      spring_mag  = product[63:16];
      spring_val  = diff_neg_ff ? -$signed({1'b0, spring_mag}) : $signed({1'b0, spring_mag});
      damp_mag    = product[63:19];
      damp_val    = rate_ff[DATA_W-1] ? -$signed({1'b0, damp_mag})
                                      : $signed({1'b0, damp_mag});
      accel_abs   = accel_ff[49] ? -accel_ff : accel_ff;
      dpos_term   = rate_ff[DATA_W-1] ? -$signed({2'b00, dpos_ff}) : $signed({2'b00, dpos_ff});
      pos_sum     = 34'(position_ff) + dpos_term;
      rate_term   = accel_ff[49] ? -$signed({1'b0, rterm_ff}) : $signed({1'b0, rterm_ff});
      rate_sum    = 51'(rate_ff) + rate_term;
   end

   always_comb begin
      step_time_in  = step_time_ff;
      step_value_in = step_value_ff;
      damping_in    = damping_ff;
      nat_freq_in   = nat_freq_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_STEP_TIME:  step_time_in  = csr_wdata;
            CSR_STEP_VALUE: step_value_in = csr_wdata;
            CSR_DAMPING:    damping_in    = csr_wdata[COEF_W-1:0];
            CSR_NAT_FREQ:   nat_freq_in   = csr_wdata[COEF_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      elapsed_in   = elapsed_ff;
      latched_in   = latched_ff;
      position_in  = position_ff;
      rate_in      = rate_ff;
      dt_in        = dt_ff;
      rate_mag_in  = rate_mag_ff;
      w2_in        = w2_ff;
      tzw_in       = tzw_ff;
      diff_neg_in  = diff_neg_ff;
      diff_mag_in  = diff_mag_ff;
      spring_in    = spring_ff;
      accel_in     = accel_ff;
      acc_mag_in   = acc_mag_ff;
      dpos_in      = dpos_ff;
      rterm_in     = rterm_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      if (req_accept) begin
         dt_in = req_tick_dt;
      end

      if (ctrl.prep) begin
         elapsed_in  = elapsed_sat;
         latched_in  = latched_ff || (elapsed_sat > step_time_ff);
         rate_mag_in = rate_ff[DATA_W-1] ? DATA_W'(-rate_ff) : DATA_W'(rate_ff);
      end

      if (ctrl.capture) begin
         unique case (ctrl.op)
            OP_W2: begin
               w2_in       = product[DATA_W-1:0];
               diff_neg_in = diff[DATA_W];
               diff_mag_in = diff_abs[DATA_W-1:0];
            end
            OP_TZW:    tzw_in    = product[DATA_W-1:0];
            OP_SPRING: spring_in = spring_val;
            OP_DAMP:   accel_in  = 50'(spring_ff) - 50'(damp_val);
            OP_DPOS: begin
               dpos_in    = product[55:24];
               acc_mag_in = accel_abs[48:0];
            end
            OP_AHI:    rterm_in  = {1'b0, product[48:0]};
            OP_ALO:    rterm_in  = rterm_ff + 50'(product[47:24]);
            default: begin
            end
         endcase
      end

      if (ctrl.finish) begin
         if (pos_sum > 34'sh0_7FFF_FFFF) begin
            position_in = 32'sh7FFF_FFFF;
         end else if (pos_sum < -34'sh0_8000_0000) begin
            position_in = 32'sh8000_0000;
         end else begin
            position_in = pos_sum[DATA_W-1:0];
         end
         if (rate_sum > 51'sh7FFF_FFFF) begin
            rate_in = 32'sh7FFF_FFFF;
         end else if (rate_sum < -51'sh8000_0000) begin
            rate_in = 32'sh8000_0000;
         end else begin
            rate_in = rate_sum[DATA_W-1:0];
         end
         rsp_valid_in = 1'b1;
         rsp_data_in  = position_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_time_ff  <= STEP_TIME_RESET;
         step_value_ff <= STEP_VALUE_RESET;
         damping_ff    <= DAMPING_RESET;
         nat_freq_ff   <= NAT_FREQ_RESET;
         elapsed_ff    <= '0;
         latched_ff    <= 1'b0;
         position_ff   <= '0;
         rate_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         step_time_ff  <= step_time_in;
         step_value_ff <= step_value_in;
         damping_ff    <= damping_in;
         nat_freq_ff   <= nat_freq_in;
         elapsed_ff    <= elapsed_in;
         latched_ff    <= latched_in;
         position_ff   <= position_in;
         rate_ff       <= rate_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dt_ff       <= dt_in;
      rate_mag_ff <= rate_mag_in;
      w2_ff       <= w2_in;
      tzw_ff      <= tzw_in;
      diff_neg_ff <= diff_neg_in;
      diff_mag_ff <= diff_mag_in;
      spring_ff   <= spring_in;
      accel_ff    <= accel_in;
      acc_mag_ff  <= acc_mag_in;
      dpos_ff     <= dpos_in;
      rterm_ff    <= rterm_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_reference_out = rsp_data_ff;

   a_finish_shows_rsp: assert property (@(posedge clock) disable iff (reset)
      ctrl.finish |=> rsp_valid_ff && rsp_data_ff == position_ff)
      else $error("update must load the response with the new position");

   a_latch_kept: assert property (@(posedge clock) disable iff (reset)
      latched_ff |=> latched_ff)
      else $error("step latch cleared without reset");

   a_elapsed_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> elapsed_ff >= $past(elapsed_ff))
      else $error("elapsed time went backwards");

   a_state_only_at_finish: assert property (@(posedge clock) disable iff (reset)
      !ctrl.finish |=> $stable(position_ff) && $stable(rate_ff))
      else $error("filter state changed outside the update");

endmodule

`default_nettype wire
